### hdl/opp_pkg.sv
// package: types, constants and the slot table lookup function for the obd2 pid poller
package opp_pkg;

  localparam int TableSlots = 29;
  localparam int SlotW = 5;

  localparam logic [2:0] ActTick  = 3'd0;
  localparam logic [2:0] ActFrame = 3'd1;
  localparam logic [2:0] ActScan  = 3'd2;
  localparam logic [2:0] ActPoll  = 3'd3;
  localparam logic [2:0] ActStop  = 3'd4;

  localparam logic [1:0] CfgPollInterval = 2'd0;
  localparam logic [1:0] CfgScanTimeout  = 2'd1;

  localparam logic [10:0] RespIdLo = 11'h7E8;
  localparam logic [10:0] RespIdHi = 11'h7EF;
  localparam logic [7:0]  SvcResp  = 8'h41;
  localparam logic [7:0]  PidLastBase = 8'h80;
  localparam logic [7:0]  PidStep  = 8'h20;
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic [15:0] PollIntervalReset = 16'd50;
  localparam logic [15:0] ScanTimeoutReset  = 16'd5000;

  localparam logic [0:0] KindRequest = 1'b0;
  localparam logic [0:0] KindValue   = 1'b1;

  typedef logic [TableSlots-1:0] marks_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [10:0] frame_id;
    logic [7:0]  service_byte;
    logic [7:0]  response_pid;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_c;
    logic [7:0]  byte_d;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         request_pid;
    logic [4:0]         slot_index;
    logic signed [30:0] decoded_value;
    logic [7:0]         raw_first;
    logic [7:0]         raw_second;
    logic               scanning_now;
    logic               polling_now;
  } out_word_t;

  function automatic logic [7:0] slot_pid(input logic [SlotW-1:0] s);
    logic [7:0] p;
    unique case (s)
      5'd0: p = 8'h0D;  5'd1: p = 8'h0C;  5'd2: p = 8'h05;  5'd3: p = 8'h11;
      5'd4: p = 8'h1F;  5'd5: p = 8'h04;  5'd6: p = 8'h06;  5'd7: p = 8'h07;
      5'd8: p = 8'h0B;  5'd9: p = 8'h0E;  5'd10: p = 8'h0F; 5'd11: p = 8'h10;
      5'd12: p = 8'h46; 5'd13: p = 8'h5C; 5'd14: p = 8'h43; 5'd15: p = 8'h2F;
      5'd16: p = 8'h5E; 5'd17: p = 8'h0A; 5'd18: p = 8'h21; 5'd19: p = 8'h31;
      5'd20: p = 8'h14; 5'd21: p = 8'h3C; 5'd22: p = 8'h33; 5'd23: p = 8'h42;
      5'd24: p = 8'h5B; 5'd25: p = 8'h59; 5'd26: p = 8'h9C; 5'd27: p = 8'h9D;
      5'd28: p = 8'h9E;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

### hdl/opp_stream_if.sv
// valid/ready stream interface carrying one word
interface opp_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/opp_decode.sv
// value decode of a data reply into thousandths
module opp_decode (
  input  logic [7:0]         pid,
  input  logic [7:0]         a,
  input  logic [7:0]         b,
  output logic signed [30:0] value
);
  import opp_pkg::*;

  logic [15:0] w;
  logic [25:0] pct_num;
  logic [25:0] pct_q;
  logic [25:0] pct_rem;
  logic signed [19:0] trim;
  logic [18:0] trim_mag;
  logic [17:0] trim_q;
  logic signed [31:0] v;

  assign w = {a, b};

  // round(a*100000/255): quotient by reciprocal, then one correction
  always_comb begin
    pct_num = 26'(a) * 26'd200000 + 26'd255;
    pct_q = 26'((50'(pct_num) * 50'd8421504) >> 32);
    pct_rem = pct_num - pct_q * 26'd510;
    if (pct_rem >= 26'd510) pct_q = pct_q + 26'd1;
  end

  // round((a-128)*3125/4), ties away from zero
  always_comb begin
    trim = (20'sd0 + $signed({12'd0, a}) - 20'sd128) * 20'sd3125;
    trim_mag = trim[19] ? 19'(-trim) : 19'(trim);
    trim_q = 18'((trim_mag + 19'd2) >> 2);
  end

  always_comb begin
    unique case (pid)
      8'h04, 8'h11, 8'h2F, 8'h43, 8'h5B: v = 32'(pct_q);
      8'h05, 8'h0F, 8'h46, 8'h5C, 8'h9C: v = (32'(a) - 32'sd40) * 32'sd1000;
      8'h06, 8'h07: v = trim[19] ? -32'(trim_q) : 32'(trim_q);
      8'h0A: v = 32'(a) * 32'sd3000;
      8'h0C: v = 32'(w) * 32'sd250;
      8'h0E: v = 32'(a) * 32'sd500 - 32'sd64000;
      8'h10: v = 32'(w) * 32'sd10;
      8'h1F, 8'h21, 8'h31: v = 32'(w) * 32'sd1000;
      8'h3C: v = 32'(w) * 32'sd100 - 32'sd40000;
      8'h42: v = 32'(w);
      8'h59: v = 32'(w) * 32'sd10000;
      8'h5E: v = 32'(w) * 32'sd50;
      8'h9D: v = 32'(w) * 32'sd100;
      8'h9E: v = 32'(w) * 32'sd100 - 32'sd3276800;
      default: v = 32'(a) * 32'sd1000;
    endcase
  end

  assign value = v[30:0];
endmodule

### hdl/obd2_pid_scan_poll_controller_top.sv
// top level: obd2 mode-01 pid scan and round-robin poll controller
// the result of an accepted word is registered in the result word register
// throughput: one input word per cycle; the result register is a one-deep
// skid so input is held only while a result waits and the sink stalls
// reset (synchronous, rst_n low): idle, marks cleared, registers at 50 and 5000
module obd2_pid_scan_poll_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  opp_stream_if.sink   in_ch,
  opp_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import opp_pkg::*;

  in_word_t  iw;
  out_word_t ow;
  logic [15:0] interval_r, timeout_r;
  logic scan_r, poll_r, scan_nxt, poll_nxt;
  logic [SlotW-1:0] pos_r, pos_nxt;
  logic [15:0] tsr_r, tsr_nxt, el_r, el_nxt;
  marks_t sup_r, sup_nxt, seen_r, seen_nxt;
  logic out_valid_r;
  out_word_t out_r;
  logic emit;
  logic accept;
  logic signed [30:0] dec;
  logic frame_ok, is_mask, in_table;
  logic [SlotW-1:0] hit_slot, found_slot;
  logic found;
  logic [31:0] mask;
  logic [7:0] p, off;

  assign iw = in_word_t'(in_ch.data);
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  opp_decode u_dec (.pid(iw.response_pid), .a(iw.byte_a), .b(iw.byte_b), .value(dec));

  assign frame_ok = iw.frame_id >= RespIdLo && iw.frame_id <= RespIdHi &&
                    iw.service_byte == SvcResp;
  assign is_mask = iw.response_pid[4:0] == 5'd0 && iw.response_pid <= PidLastBase;
  assign mask = {iw.byte_a, iw.byte_b, iw.byte_c, iw.byte_d};

  // table lookup of the reply pid
  always_comb begin
    in_table = 1'b0;
    hit_slot = '0;
    for (int j = TableSlots - 1; j >= 0; j--) begin
      if (slot_pid(SlotW'(j)) == iw.response_pid) begin
        in_table = 1'b1;
        hit_slot = SlotW'(j);
      end
    end
  end

  // next state and result
  always_comb begin
    scan_nxt = scan_r; poll_nxt = poll_r; pos_nxt = pos_r;
    tsr_nxt = tsr_r; el_nxt = el_r; sup_nxt = sup_r; seen_nxt = seen_r;
    emit = 1'b0; ow = '0; found = 1'b0; found_slot = '0; p = '0; off = '0;
    unique case (iw.action)
      ActTick: begin
        if (tsr_nxt != CountMax) tsr_nxt = tsr_nxt + 16'd1;
        if (scan_r) begin
          if (el_nxt != CountMax) el_nxt = el_nxt + 16'd1;
          if (el_nxt >= timeout_r) begin
            scan_nxt = 1'b0; poll_nxt = 1'b1; pos_nxt = '0; el_nxt = '0;
            sup_nxt = '1;
          end
        end
        if (poll_nxt && tsr_nxt >= interval_r) begin
          tsr_nxt = '0;
          for (int j = TableSlots - 1; j >= 0; j--) begin
            if (SlotW'(j) >= pos_nxt && sup_nxt[j]) begin
              found = 1'b1; found_slot = SlotW'(j);
            end
          end
          if (found) begin
            emit = 1'b1;
            ow.result_kind = KindRequest;
            ow.request_pid = slot_pid(found_slot);
            pos_nxt = found_slot + SlotW'(1);
          end else begin
            pos_nxt = '0;
          end
        end
      end
      ActFrame: begin
        if (frame_ok) begin
          if (is_mask) begin
            for (int j = 0; j < TableSlots; j++) begin
              p = slot_pid(SlotW'(j));
              off = p - iw.response_pid - 8'd1;
              if (p > iw.response_pid && 9'(p) <= 9'(iw.response_pid) + 9'd32 &&
                  mask[5'(31 - 32'(off))])
                sup_nxt[j] = 1'b1;
            end
            if (scan_r) begin
              if (iw.response_pid < PidLastBase) begin
                emit = 1'b1;
                ow.result_kind = KindRequest;
                ow.request_pid = iw.response_pid + PidStep;
              end else begin
                scan_nxt = 1'b0; poll_nxt = 1'b1; pos_nxt = '0; tsr_nxt = CountMax;
              end
            end
          end else if (in_table) begin
            emit = 1'b1;
            seen_nxt[hit_slot] = 1'b1;
            ow.result_kind = KindValue;
            ow.slot_index = hit_slot;
            ow.decoded_value = dec;
            ow.raw_first = iw.byte_a;
            ow.raw_second = iw.byte_b;
          end
        end
      end
      ActScan: begin
        scan_nxt = 1'b1; poll_nxt = 1'b0; el_nxt = '0; sup_nxt = '0; seen_nxt = '0;
        emit = 1'b1;
        ow.result_kind = KindRequest;
        ow.request_pid = 8'h00;
      end
      ActPoll: begin
        poll_nxt = 1'b1; pos_nxt = '0; tsr_nxt = CountMax;
      end
      ActStop: begin
        scan_nxt = 1'b0; poll_nxt = 1'b0;
      end
      default: ;
    endcase
    ow.scanning_now = scan_nxt;
    ow.polling_now = poll_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= 1'b0; poll_r <= 1'b0; pos_r <= '0; tsr_r <= '0; el_r <= '0;
      sup_r <= '0; seen_r <= '0; out_valid_r <= 1'b0;
      interval_r <= PollIntervalReset; timeout_r <= ScanTimeoutReset;
    end else begin
      if (cfg_we && cfg_index == CfgPollInterval) interval_r <= cfg_wdata;
      if (cfg_we && cfg_index == CfgScanTimeout) timeout_r <= cfg_wdata;
      if (accept) begin
        scan_r <= scan_nxt; poll_r <= poll_nxt; pos_r <= pos_nxt;
        tsr_r <= tsr_nxt; el_r <= el_nxt; sup_r <= sup_nxt; seen_r <= seen_nxt;
      end
      if (in_ch.ready) out_valid_r <= accept && emit;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (accept && emit) out_r <= ow;
  end
endmodule

### bench/obd2_pid_scan_poll_controller_top_tb.sv
// testbench for the obd2 pid scan and poll controller: predicted results checked per word
`timescale 1ns / 100ps

module obd2_pid_scan_poll_controller_top_tb;
  import opp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  opp_stream_if #(.W($bits(in_word_t)))  in_ch ();
  opp_stream_if #(.W($bits(out_word_t))) out_ch ();

  obd2_pid_scan_poll_controller_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // pid of each table slot
  localparam logic [7:0] PidTable [TableSlots] = '{
    8'h0D, 8'h0C, 8'h05, 8'h11, 8'h1F, 8'h04, 8'h06, 8'h07, 8'h0B, 8'h0E,
    8'h0F, 8'h10, 8'h46, 8'h5C, 8'h43, 8'h2F, 8'h5E, 8'h0A, 8'h21, 8'h31,
    8'h14, 8'h3C, 8'h33, 8'h42, 8'h5B, 8'h59, 8'h9C, 8'h9D, 8'h9E
  };

  // poller state mirror, expected words and mismatch bookkeeping
  class poller_scoreboard;
    out_word_t   pending[$];
    int          mismatches;
    int          orphans;
    int          words_in;
    int          results_seen;
    int          requests_seen;
    int          updates_seen;
    int unsigned interval;
    int unsigned timeout;
    bit          scanning;
    bit          polling;
    int          position;
    int unsigned since_req;
    int unsigned elapsed;
    bit          supported [TableSlots];

    function new();
      interval = PollIntervalReset;
      timeout  = ScanTimeoutReset;
      foreach (supported[j]) supported[j] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CfgPollInterval) interval = val;
      else if (idx == CfgScanTimeout) timeout = val;
    endfunction

    // rounded division, ties away from zero
    function longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag * 2 + den) / (2 * den);
      return (num < 0) ? -q : q;
    endfunction

    function longint milli_value(logic [7:0] pid, logic [7:0] a, logic [7:0] b);
      longint ai;
      longint w;
      ai = a;
      w = a * 256 + b;
      case (pid)
        8'h04, 8'h11, 8'h2F, 8'h43, 8'h5B: return round_div(ai * 100000, 255);
        8'h05, 8'h0F, 8'h46, 8'h5C, 8'h9C: return (ai - 40) * 1000;
        8'h06, 8'h07: return round_div((ai - 128) * 3125, 4);
        8'h0A: return ai * 3000;
        8'h0C: return w * 250;
        8'h0E: return ai * 500 - 64000;
        8'h10: return w * 10;
        8'h1F, 8'h21, 8'h31: return w * 1000;
        8'h3C: return w * 100 - 40000;
        8'h42: return w;
        8'h59: return w * 10000;
        8'h5E: return w * 50;
        8'h9D: return w * 100;
        8'h9E: return w * 100 - 3276800;
        default: return ai * 1000;
      endcase
    endfunction

    function void begin_polling();
      polling = 1'b1;
      position = 0;
      since_req = CountMax;
    endfunction

    // advance the mirror by one accepted word, queue its result if any
    function void note_word(in_word_t w);
      out_word_t r;
      bit        emit;
      int        found;
      logic [31:0] mask;
      int        off;
      longint    v;
      r = '0;
      emit = 1'b0;
      words_in++;
      case (w.action)
        ActTick: begin
          if (since_req < CountMax) since_req++;
          if (scanning) begin
            if (elapsed < CountMax) elapsed++;
            if (elapsed >= timeout) begin
              scanning = 1'b0;
              polling = 1'b1;
              position = 0;
              elapsed = 0;
              foreach (supported[j]) supported[j] = 1'b1;
            end
          end
          if (polling && since_req >= interval) begin
            since_req = 0;
            found = -1;
            for (int j = position; j < TableSlots; j++)
              if (found < 0 && supported[j]) found = j;
            if (found >= 0) begin
              r.result_kind = KindRequest;
              r.request_pid = PidTable[found];
              position = found + 1;
              emit = 1'b1;
            end else begin
              position = 0;
            end
          end
        end
        ActFrame: begin
          if (w.frame_id >= RespIdLo && w.frame_id <= RespIdHi &&
              w.service_byte == SvcResp) begin
            if (w.response_pid[4:0] == 5'd0 && w.response_pid <= PidLastBase) begin
              mask = {w.byte_a, w.byte_b, w.byte_c, w.byte_d};
              for (int j = 0; j < TableSlots; j++) begin
                off = int'(PidTable[j]) - int'(w.response_pid);
                if (off >= 1 && off <= 32 && mask[32 - off]) supported[j] = 1'b1;
              end
              if (scanning) begin
                if (w.response_pid < PidLastBase) begin
                  r.result_kind = KindRequest;
                  r.request_pid = w.response_pid + PidStep;
                  emit = 1'b1;
                end else begin
                  scanning = 1'b0;
                  begin_polling();
                end
              end
            end else begin
              for (int j = 0; j < TableSlots; j++) begin
                if (!emit && PidTable[j] == w.response_pid) begin
                  v = milli_value(w.response_pid, w.byte_a, w.byte_b);
                  r.result_kind = KindValue;
                  r.slot_index = 5'(j);
                  r.decoded_value = v[30:0];
                  r.raw_first = w.byte_a;
                  r.raw_second = w.byte_b;
                  emit = 1'b1;
                end
              end
            end
          end
        end
        ActScan: begin
          scanning = 1'b1;
          polling = 1'b0;
          elapsed = 0;
          foreach (supported[j]) supported[j] = 1'b0;
          r.result_kind = KindRequest;
          r.request_pid = 8'h00;
          emit = 1'b1;
        end
        ActPoll: begin_polling();
        ActStop: begin
          scanning = 1'b0;
          polling = 1'b0;
        end
        default: ;
      endcase
      if (emit) begin
        r.scanning_now = scanning;
        r.polling_now = polling;
        pending.push_back(r);
      end
    endfunction

    // compare one delivered word with the oldest expectation
    function void check_word(out_word_t g);
      out_word_t e;
      bit bad;
      results_seen++;
      if (pending.size() == 0) begin
        orphans++;
        if (mismatches + orphans <= 10) $display("unexpected result word %h", g);
        return;
      end
      e = pending.pop_front();
      if (e.result_kind == KindRequest) requests_seen++;
      else updates_seen++;
      bad = (g.result_kind !== e.result_kind) || (g.request_pid !== e.request_pid) ||
            (g.slot_index !== e.slot_index) || (g.decoded_value !== e.decoded_value) ||
            (g.raw_first !== e.raw_first) || (g.raw_second !== e.raw_second) ||
            (g.scanning_now !== e.scanning_now) || (g.polling_now !== e.polling_now);
      if (bad) begin
        mismatches++;
        if (mismatches + orphans <= 10) begin
          $display("mismatch kind %0d/%0d pid %h/%h slot %0d/%0d val %0d/%0d",
                   e.result_kind, g.result_kind, e.request_pid, g.request_pid,
                   e.slot_index, g.slot_index, e.decoded_value, g.decoded_value);
          $display("  raw %h%h/%h%h flags %b%b/%b%b",
                   e.raw_first, e.raw_second, g.raw_first, g.raw_second,
                   e.scanning_now, e.polling_now, g.scanning_now, g.polling_now);
        end
      end
    endfunction
  endclass

  poller_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  bit hold_go;
  bit hold_seen;

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls and one long hold-off
  always @(posedge clk) begin
    hold_seen <= hold_go;
    if (hold_go && !hold_seen) begin
      hold_cycles <= 299;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: results first, then the accepted input word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_word(out_word_t'(out_ch.data));
      if (in_ch.valid && in_ch.ready) sb.note_word(in_word_t'(in_ch.data));
    end
  end

  // offer one word, with an optional gap before it
  task automatic send_word(in_word_t w);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // wait until no result is outstanding, then write a register
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic in_word_t frame_word(logic [7:0] pid, logic [7:0] a, logic [7:0] b,
                                          logic [7:0] c, logic [7:0] d);
    in_word_t w;
    w = '0;
    w.action = ActFrame;
    w.frame_id = 11'(RespIdLo + $urandom_range(7));
    w.service_byte = SvcResp;
    w.response_pid = pid;
    w.byte_a = a;
    w.byte_b = b;
    w.byte_c = c;
    w.byte_d = d;
    return w;
  endfunction

  function automatic in_word_t cmd_word(logic [2:0] act);
    in_word_t w;
    w = '0;
    w.action = act;
    return w;
  endfunction

  // byte biased toward its extremes
  function automatic logic [7:0] edge_byte();
    int r;
    r = $urandom_range(9);
    if (r < 2) return 8'h00;
    if (r < 4) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // mostly well-formed traffic with some noise
  function automatic in_word_t random_word();
    in_word_t w;
    int r;
    logic [7:0] pid;
    r = $urandom_range(99);
    if (r < 40) return cmd_word(ActTick);
    if (r < 76) begin
      case ($urandom_range(3))
        0, 1: pid = PidTable[$urandom_range(TableSlots - 1)];
        2: pid = 8'(PidStep * $urandom_range(4));
        default: pid = 8'($urandom_range(255));
      endcase
      return frame_word(pid, edge_byte(), edge_byte(), edge_byte(), edge_byte());
    end
    if (r < 80) return cmd_word(ActScan);
    if (r < 84) return cmd_word(ActPoll);
    if (r < 87) return cmd_word(ActStop);
    w = in_word_t'(62'({$urandom, $urandom}));
    if ($urandom_range(1)) begin
      w.action = ActFrame;
      if ($urandom_range(1)) w.frame_id = $urandom_range(1) ? 11'(RespIdLo - 1) : 11'(RespIdHi + 1);
      else w.service_byte = SvcResp ^ (8'h1 << $urandom_range(7));
    end
    return w;
  endfunction

  // limit on the whole run
  initial begin
    #8ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int intervals [4];
    int timeouts [4];
    int cyc;
    in_word_t w;
    intervals = '{1, 65535, 3, 2};
    timeouts = '{1, 65535, 40, 12};
    sb = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full scan sequence, rejects, ignored codes, commands
    send_idle_pct = 27;
    recv_idle_pct = 49;
    write_reg(CfgPollInterval, 16'd2);
    send_word(cmd_word(ActScan));
    send_word(frame_word(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(frame_word(8'h20, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(frame_word(8'h40, 8'hA5, 8'h5A, 8'hFF, 8'h00));
    send_word(frame_word(8'h60, 8'h00, 8'hFF, 8'h00, 8'hFF));
    send_word(frame_word(8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    repeat (3) send_word(cmd_word(ActTick));
    send_word(frame_word(8'h9E, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(frame_word(8'h59, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(frame_word(8'h06, 8'h00, 8'h01, 8'h00, 8'h00));
    send_word(frame_word(8'h04, 8'h7F, 8'h00, 8'h00, 8'h00));
    send_word(frame_word(8'h01, 8'h12, 8'h34, 8'h00, 8'h00));
    w = frame_word(8'h0D, 8'h10, 8'h00, 8'h00, 8'h00);
    w.frame_id = RespIdLo - 1;
    send_word(w);
    w.frame_id = RespIdHi + 1;
    send_word(w);
    w.frame_id = RespIdHi;
    w.service_byte = 8'h40;
    send_word(w);
    send_word(cmd_word(3'd5));
    send_word(cmd_word(3'd7));
    send_word(cmd_word(ActStop));
    send_word(frame_word(8'h00, 8'hFF, 8'h00, 8'h00, 8'h01));
    send_word(cmd_word(ActPoll));
    send_word(cmd_word(ActTick));

    // random phases over several register settings
    for (int p = 0; p < 4; p++) begin
      write_reg(CfgPollInterval, 16'(intervals[p]));
      write_reg(CfgScanTimeout, 16'(timeouts[p]));
      send_word(cmd_word(ActScan));
      for (int k = 0; k < 300; k++) begin
        cyc = p * 300 + k;
        if (cyc == 400) begin
          send_idle_pct = 49;
          recv_idle_pct = 27;
        end else if (cyc == 800) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_go <= 1'b1;
        end
        send_word(random_word());
      end
    end
    in_ch.valid <= 1'b0;

    // drain outstanding results
    cyc = 0;
    while (sb.pending.size() != 0 && cyc < 5000) begin
      @(posedge clk);
      cyc++;
    end
    repeat (10) @(posedge clk);
    $display("covered %0d input words and %0d results (%0d requests, %0d value updates)",
             sb.words_in, sb.results_seen, sb.requests_seen, sb.updates_seen);
    $display("register settings from 1 to 65535 with sender and receiver stalls");
    if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing",
               sb.mismatches, sb.orphans, sb.pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
